// ===== hdl/space_vector_pwm_timing_macros.svh =====
// ----------------------------------------------------------------------------
// Space vector PWM timing: assertion macros
// Shared concurrent assertion forms for the timing generator and its divider.
// ----------------------------------------------------------------------------
`ifndef SPACE_VECTOR_PWM_TIMING_MACROS_SVH
`define SPACE_VECTOR_PWM_TIMING_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SVPWM_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SVPWM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/svpwm_pkg.sv =====
// ----------------------------------------------------------------------------
// Space vector PWM timing: package
// Transaction types, sector codes and duty modes shared by the pipeline.
// ----------------------------------------------------------------------------
package svpwm_pkg;

  // Width of the duty fraction, which is also the number of divider stages.
  localparam int DUTY_BITS = 15;

  // sqrt(3)/2 in Q1.15.
  localparam logic signed [15:0] SQRT3_HALF_Q15 = 16'sd28378;

  // Largest duty fraction, reported on overmodulation.
  localparam logic [DUTY_BITS-1:0] DUTY_MAX = '1;

  // Sector numbers.
  localparam logic [2:0] SECTOR_1 = 3'd1;
  localparam logic [2:0] SECTOR_2 = 3'd2;
  localparam logic [2:0] SECTOR_3 = 3'd3;
  localparam logic [2:0] SECTOR_4 = 3'd4;
  localparam logic [2:0] SECTOR_5 = 3'd5;
  localparam logic [2:0] SECTOR_6 = 3'd6;

  // How the duty fraction of a transaction is formed.
  typedef enum logic [1:0] {
    DUTY_DIVIDE = 2'd0,
    DUTY_FULL   = 2'd1,
    DUTY_ZERO   = 2'd2
  } duty_mode_t;

  // Control that travels with each divider stage.
  typedef struct packed {
    logic       valid;
    duty_mode_t mode;
  } div_ctrl_t;

  // Input transaction.
  typedef struct packed {
    logic signed [15:0] alpha_volts;
    logic signed [15:0] beta_volts;
  } svpwm_in_t;

  // Result transaction.
  typedef struct packed {
    logic [15:0]          phase_a_count;
    logic [15:0]          phase_b_count;
    logic [15:0]          phase_c_count;
    logic [2:0]           sector;
    logic [DUTY_BITS-1:0] duty_fraction;
  } svpwm_out_t;

endpackage

// ===== hdl/svpwm_div.sv =====
// ----------------------------------------------------------------------------
// Space vector PWM timing: duty divider
// Pipelined restoring divider, one quotient bit per stage, forming
// floor(num * 2^15 / period) for num below period. The rest of the result
// transaction rides alongside and the duty mode picks the final value.
// ----------------------------------------------------------------------------
module svpwm_div
  import svpwm_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  div_ctrl_t   in_ctrl,
  input  logic [15:0] in_num,
  input  svpwm_out_t  in_side,
  input  logic [15:0] period,
  output logic        out_valid,
  output svpwm_out_t  out_result
);

`include "space_vector_pwm_timing_macros.svh"

  // Stage registers.
  div_ctrl_t            stage_ctrl [DUTY_BITS];
  logic [15:0]          stage_rem  [DUTY_BITS];
  logic [DUTY_BITS-1:0] stage_quo  [DUTY_BITS];
  svpwm_out_t           stage_side [DUTY_BITS];

  // Values entering each stage.
  div_ctrl_t            prev_ctrl [DUTY_BITS];
  logic [15:0]          prev_rem  [DUTY_BITS];
  logic [DUTY_BITS-1:0] prev_quo  [DUTY_BITS];
  svpwm_out_t           prev_side [DUTY_BITS];

  for (genvar k = 0; k < DUTY_BITS; k++) begin : g_stage
    logic [16:0] dbl;
    logic        take;

    // Stage inputs come from the port or the stage before.
    if (k == 0) begin : g_first
      assign prev_ctrl[k] = in_ctrl;
      assign prev_rem[k]  = in_num;
      assign prev_quo[k]  = '0;
      assign prev_side[k] = in_side;
    end else begin : g_next
      assign prev_ctrl[k] = stage_ctrl[k-1];
      assign prev_rem[k]  = stage_rem[k-1];
      assign prev_quo[k]  = stage_quo[k-1];
      assign prev_side[k] = stage_side[k-1];
    end

    // One restoring step: double the remainder and subtract if it fits.
    assign dbl  = {prev_rem[k], 1'b0};
    assign take = (dbl >= {1'b0, period});

    always_ff @(posedge clk) begin
      if (rst) begin
        stage_ctrl[k].valid <= 1'b0;
      end else begin
        stage_ctrl[k].valid <= prev_ctrl[k].valid;
      end
      stage_ctrl[k].mode <= prev_ctrl[k].mode;
      stage_rem[k]       <= take ? 16'(dbl - {1'b0, period}) : dbl[15:0];
      stage_quo[k]       <= {prev_quo[k][DUTY_BITS-2:0], take};
      stage_side[k]      <= prev_side[k];
    end
  end

  // Final duty selection.
  always_comb begin
    out_result = stage_side[DUTY_BITS-1];
    case (stage_ctrl[DUTY_BITS-1].mode)
      DUTY_FULL:   out_result.duty_fraction = DUTY_MAX;
      DUTY_ZERO:   out_result.duty_fraction = '0;
      default:     out_result.duty_fraction = stage_quo[DUTY_BITS-1];
    endcase
  end

  assign out_valid = stage_ctrl[DUTY_BITS-1].valid;

  // A dividend must be below the period for the quotient to fit.
  `SVPWM_ASSERT_IMPLY(a_div_num_range, clk, rst, in_ctrl.valid && in_ctrl.mode == DUTY_DIVIDE, in_num < period, "divider input not below period")
  // The remainder stays below the period through the whole chain.
  `SVPWM_ASSERT_IMPLY(a_div_rem_range, clk, rst, out_valid && stage_ctrl[DUTY_BITS-1].mode == DUTY_DIVIDE, stage_rem[DUTY_BITS-1] < period, "divider remainder out of range")
  // An entering transaction reaches the first stage on the next cycle.
  `SVPWM_ASSERT_NEXT(a_div_valid_step, clk, rst, in_ctrl.valid, stage_ctrl[0].valid, "divider dropped a transaction")

endmodule

// ===== hdl/space_vector_pwm_timing.sv =====
// ----------------------------------------------------------------------------
// Space vector PWM timing generator
// Turns an alpha/beta voltage pair into three centered compare counts, the
// sector number and the active duty fraction for one PWM period.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake               Payload
//  -------   ---------------------   -------------------------------------
//  input     start / busy            volts  (alpha_volts, beta_volts)
//  result    result_valid (strobe)   result (phase counts, sector, duty)
//  config    cfg_valid / cfg_ready   cfg_data (pwm_period)
//
//  A transaction is taken every cycle while busy is low; its result strobes
//  after seven arithmetic stages, fifteen divider stages and the output register.
//  The divider chain, one quotient bit per stage, sets the depth.
//  busy is held high and cfg_ready low during reset and the cycle after it.
//  The receiver cannot stall, so the pipeline never holds.
//
module space_vector_pwm_timing
  import svpwm_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  svpwm_in_t   volts,
  output logic        result_valid,
  output svpwm_out_t  result,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);

`include "space_vector_pwm_timing_macros.svh"

  // Clamp a signed count to 0..period.
  function automatic logic [15:0] clamp_count(input logic signed [19:0] v,
                                              input logic [15:0] p);
    logic [15:0] r;
    if (v < 0) begin
      r = '0;
    end else if (v > $signed({4'b0, p})) begin
      r = p;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

  logic [15:0] pwm_period;
  logic [5:0]  stage_valid;

  // Stage 1: input and cross product.
  logic signed [15:0] s1_beta;
  logic signed [30:0] s1_cross;
  logic signed [31:0] cross_prod;

  // Stage 2: reference voltages in Q2.30.
  logic signed [31:0] s2_vr1, s2_vr2, s2_vr3;
  logic signed [31:0] cross_ext, half_ext, vr1_ext;

  // Stage 3: sector and active vector lengths.
  logic [2:0]  s3_sector;
  logic [30:0] s3_tv1, s3_tv2;
  logic [2:0]  sector_next;
  logic [30:0] tv1_next, tv2_next;
  logic signed [31:0] neg_vr1, neg_vr2, neg_vr3;

  // Stage 4: scaled times.
  logic [2:0]  s4_sector;
  logic [16:0] s4_t1, s4_t2;
  logic [46:0] t1_prod, t2_prod;

  // Stage 5: sum and zero time.
  logic [2:0]         s5_sector;
  logic [16:0]        s5_t2;
  logic [17:0]        s5_sum;
  logic signed [18:0] s5_diff;
  logic [17:0]        sum_next;

  // Stage 6: unclamped compare counts.
  logic [2:0]         s6_sector;
  logic [17:0]        s6_sum;
  logic signed [19:0] s6_ta, s6_tb, s6_tc;
  logic signed [18:0] tc_next;

  // Stage 7: clamped, permuted counts and duty mode.
  div_ctrl_t   s7_ctrl;
  logic [15:0] s7_num;
  svpwm_out_t  s7_side;
  svpwm_out_t  side_next;
  duty_mode_t  mode_next;
  logic [15:0] ca, cb, cc;

  logic       div_valid;
  svpwm_out_t div_result;

  // Handshake and configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy       <= 1'b1;
      pwm_period <= '0;
    end else begin
      busy <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        pwm_period <= cfg_data;
      end
    end
  end

  assign cfg_ready = !busy;

  // Valid bits of the arithmetic stages.
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= '0;
    end else begin
      stage_valid <= {stage_valid[4:0], start && !busy};
    end
  end

  // Stage 1.
  assign cross_prod = 32'(volts.alpha_volts) * 32'(SQRT3_HALF_Q15);

  always_ff @(posedge clk) begin
    s1_beta  <= volts.beta_volts;
    s1_cross <= cross_prod[30:0];
  end

  // Stage 2.
  assign cross_ext = {s1_cross[30], s1_cross};
  assign half_ext  = {{2{s1_beta[15]}}, s1_beta, 14'b0};
  assign vr1_ext   = {s1_beta[15], s1_beta, 15'b0};

  always_ff @(posedge clk) begin
    s2_vr1 <= vr1_ext;
    s2_vr2 <= cross_ext - half_ext;
    s2_vr3 <= -cross_ext - half_ext;
  end

  // Stage 3: sector decode from the signs of the references.
  assign neg_vr1 = -s2_vr1;
  assign neg_vr2 = -s2_vr2;
  assign neg_vr3 = -s2_vr3;

  always_comb begin
    if (!s2_vr1[31]) begin
      if (!s2_vr2[31]) begin
        sector_next = SECTOR_3;
        tv1_next    = s2_vr2[30:0];
        tv2_next    = s2_vr1[30:0];
      end else if (!s2_vr3[31]) begin
        sector_next = SECTOR_5;
        tv1_next    = s2_vr1[30:0];
        tv2_next    = s2_vr3[30:0];
      end else begin
        sector_next = SECTOR_1;
        tv1_next    = neg_vr2[30:0];
        tv2_next    = neg_vr3[30:0];
      end
    end else if (!s2_vr2[31]) begin
      if (!s2_vr3[31]) begin
        sector_next = SECTOR_6;
        tv1_next    = s2_vr3[30:0];
        tv2_next    = s2_vr2[30:0];
      end else begin
        sector_next = SECTOR_2;
        tv1_next    = neg_vr3[30:0];
        tv2_next    = neg_vr1[30:0];
      end
    end else begin
      sector_next = SECTOR_4;
      tv1_next    = neg_vr1[30:0];
      tv2_next    = neg_vr2[30:0];
    end
  end

  always_ff @(posedge clk) begin
    s3_sector <= sector_next;
    s3_tv1    <= tv1_next;
    s3_tv2    <= tv2_next;
  end

  // Stage 4: scale the period by each vector length, truncating.
  assign t1_prod = 47'(pwm_period) * 47'(s3_tv1);
  assign t2_prod = 47'(pwm_period) * 47'(s3_tv2);

  always_ff @(posedge clk) begin
    s4_sector <= s3_sector;
    s4_t1     <= t1_prod[46:30];
    s4_t2     <= t2_prod[46:30];
  end

  // Stage 5: active time and remaining zero time.
  assign sum_next = {1'b0, s4_t1} + {1'b0, s4_t2};

  always_ff @(posedge clk) begin
    s5_sector <= s4_sector;
    s5_t2     <= s4_t2;
    s5_sum    <= sum_next;
    s5_diff   <= $signed({3'b0, pwm_period}) - $signed({1'b0, sum_next});
  end

  // Stage 6: halve toward zero, then build the three counts.
  assign tc_next = (s5_diff + $signed({18'b0, s5_diff[18]})) >>> 1;

  always_ff @(posedge clk) begin
    s6_sector <= s5_sector;
    s6_sum    <= s5_sum;
    s6_tc     <= 20'(tc_next);
    s6_tb     <= 20'(tc_next) + $signed({3'b0, s5_t2});
    s6_ta     <= 20'(tc_next) + $signed({2'b0, s5_sum});
  end

  // Stage 7: clamp, permute by sector and choose how duty is formed.
  assign ca = clamp_count(s6_ta, pwm_period);
  assign cb = clamp_count(s6_tb, pwm_period);
  assign cc = clamp_count(s6_tc, pwm_period);

  always_comb begin
    side_next               = '0;
    side_next.sector        = s6_sector;
    case (s6_sector)
      SECTOR_3: begin
        side_next.phase_a_count = ca;
        side_next.phase_b_count = cb;
        side_next.phase_c_count = cc;
      end
      SECTOR_5: begin
        side_next.phase_a_count = cc;
        side_next.phase_b_count = ca;
        side_next.phase_c_count = cb;
      end
      SECTOR_1: begin
        side_next.phase_a_count = cb;
        side_next.phase_b_count = ca;
        side_next.phase_c_count = cc;
      end
      SECTOR_6: begin
        side_next.phase_a_count = cb;
        side_next.phase_b_count = cc;
        side_next.phase_c_count = ca;
      end
      SECTOR_2: begin
        side_next.phase_a_count = ca;
        side_next.phase_b_count = cc;
        side_next.phase_c_count = cb;
      end
      default: begin
        side_next.phase_a_count = cc;
        side_next.phase_b_count = cb;
        side_next.phase_c_count = ca;
      end
    endcase

    if (pwm_period == '0) begin
      mode_next = DUTY_ZERO;
    end else if (s6_sum >= {2'b0, pwm_period}) begin
      mode_next = DUTY_FULL;
    end else begin
      mode_next = DUTY_DIVIDE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s7_ctrl.valid <= 1'b0;
    end else begin
      s7_ctrl.valid <= stage_valid[5];
    end
    s7_ctrl.mode <= mode_next;
    s7_num       <= (mode_next == DUTY_DIVIDE) ? s6_sum[15:0] : '0;
    s7_side      <= side_next;
  end

  // Duty fraction divider.
  svpwm_div u_div (
    .clk        (clk),
    .rst        (rst),
    .in_ctrl    (s7_ctrl),
    .in_num     (s7_num),
    .in_side    (s7_side),
    .period     (pwm_period),
    .out_valid  (div_valid),
    .out_result (div_result)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= div_valid;
    end
    result <= div_result;
  end

  // A result always carries a sector in range.
  `SVPWM_ASSERT_IMPLY(a_sector_range, clk, rst, result_valid, result.sector >= SECTOR_1 && result.sector <= SECTOR_6, "sector out of range")
  // Compare counts never exceed the period.
  `SVPWM_ASSERT_IMPLY(a_count_range, clk, rst, result_valid, result.phase_a_count <= pwm_period && result.phase_b_count <= pwm_period && result.phase_c_count <= pwm_period, "compare count above period")
  // A zero period gives zero counts and zero duty.
  `SVPWM_ASSERT_IMPLY(a_zero_period, clk, rst, result_valid && pwm_period == '0, result.phase_a_count == '0 && result.phase_b_count == '0 && result.phase_c_count == '0 && result.duty_fraction == '0, "nonzero output at zero period")

endmodule

// ===== sim/svpwm_timing_checker.sv =====
// ----------------------------------------------------------------------------
// Space vector PWM timing: transaction checker
// Watches the input, result and configuration channels of the timing
// generator. Every accepted input transaction gets a predicted result, and
// each result strobe is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module svpwm_timing_checker
  import svpwm_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        busy,
  input  svpwm_in_t   volts,
  input  logic        result_valid,
  input  svpwm_out_t  result,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [15:0] cfg_data,
  output int          outstanding,
  output int          mismatches
);

  timeunit 1ns;
  timeprecision 1ps;

  // Period copy and the timings still waiting for their result strobe.
  logic [15:0] period_copy;
  svpwm_out_t  expected_timings[$];
  int          fail_count;

  initial begin
    period_copy = '0;
    fail_count  = 0;
    outstanding = 0;
    mismatches  = 0;
  end

  function automatic longint clamp_to_period(longint v, longint p);
    if (v < 0) return 0;
    if (v > p) return p;
    return v;
  endfunction

  // Inverse Clarke, sector decode, vector times and centered compare counts.
  function automatic svpwm_out_t compute_switch_timing(svpwm_in_t v, logic [15:0] period);
    longint     a, b, p, k;
    longint     vr1, vr2, vr3, tv1, tv2;
    longint     t1, t2, ta, tb, tc, ca, cb, cc, duty;
    logic [2:0] sec;
    svpwm_out_t r;
    a = longint'($signed(v.alpha_volts));
    b = longint'($signed(v.beta_volts));
    p = longint'(period);
    k = longint'(SQRT3_HALF_Q15);
    vr1 = b * 32768;
    vr2 = -b * 16384 + k * a;
    vr3 = -b * 16384 - k * a;

    // The signs of the three references select the sector and active vectors.
    if (vr1 >= 0) begin
      if (vr2 >= 0) begin
        sec = SECTOR_3; tv1 = vr2; tv2 = vr1;
      end else if (vr3 >= 0) begin
        sec = SECTOR_5; tv1 = vr1; tv2 = vr3;
      end else begin
        sec = SECTOR_1; tv1 = -vr2; tv2 = -vr3;
      end
    end else begin
      if (vr2 >= 0) begin
        if (vr3 >= 0) begin
          sec = SECTOR_6; tv1 = vr3; tv2 = vr2;
        end else begin
          sec = SECTOR_2; tv1 = -vr3; tv2 = -vr1;
        end
      end else begin
        sec = SECTOR_4; tv1 = -vr1; tv2 = -vr2;
      end
    end

    // Vector times are non-negative, so the shift truncates toward zero.
    t1 = (p * tv1) >> 30;
    t2 = (p * tv2) >> 30;
    tc = (p - t1 - t2) / 2;
    tb = tc + t2;
    ta = tb + t1;
    ca = clamp_to_period(ta, p);
    cb = clamp_to_period(tb, p);
    cc = clamp_to_period(tc, p);

    duty = 0;
    if (p > 0) begin
      duty = ((t1 + t2) * 32768) / p;
      if (duty > 32767) duty = 32767;
    end

    // Map the three counts onto the phases by sector.
    case (sec)
      SECTOR_3: begin
        r.phase_a_count = ca[15:0]; r.phase_b_count = cb[15:0]; r.phase_c_count = cc[15:0];
      end
      SECTOR_5: begin
        r.phase_a_count = cc[15:0]; r.phase_b_count = ca[15:0]; r.phase_c_count = cb[15:0];
      end
      SECTOR_1: begin
        r.phase_a_count = cb[15:0]; r.phase_b_count = ca[15:0]; r.phase_c_count = cc[15:0];
      end
      SECTOR_6: begin
        r.phase_a_count = cb[15:0]; r.phase_b_count = cc[15:0]; r.phase_c_count = ca[15:0];
      end
      SECTOR_2: begin
        r.phase_a_count = ca[15:0]; r.phase_b_count = cc[15:0]; r.phase_c_count = cb[15:0];
      end
      default: begin
        r.phase_a_count = cc[15:0]; r.phase_b_count = cb[15:0]; r.phase_c_count = ca[15:0];
      end
    endcase
    r.sector        = sec;
    r.duty_fraction = duty[DUTY_BITS-1:0];
    return r;
  endfunction

  task automatic compare_field(string name, longint exp_val, longint act_val);
    if (exp_val !== act_val) begin
      $error("%s: expected %0d, got %0d", name, exp_val, act_val);
      fail_count++;
    end
  endtask

  // Signals are sampled as they stood before the edge.
  always @(posedge clk) begin
    svpwm_out_t want;
    if (rst) begin
      period_copy = '0;
      expected_timings.delete();
    end else begin
      if (result_valid) begin
        if (expected_timings.size() == 0) begin
          $error("result strobe with no transaction outstanding");
          fail_count++;
        end else begin
          want = expected_timings.pop_front();
          compare_field("phase_a_count", want.phase_a_count, result.phase_a_count);
          compare_field("phase_b_count", want.phase_b_count, result.phase_b_count);
          compare_field("phase_c_count", want.phase_c_count, result.phase_c_count);
          compare_field("sector", want.sector, result.sector);
          compare_field("duty_fraction", want.duty_fraction, result.duty_fraction);
        end
      end
      if (start && !busy) expected_timings.push_back(compute_switch_timing(volts, period_copy));
      if (cfg_valid && cfg_ready) period_copy = cfg_data;
    end
    outstanding <= expected_timings.size();
    mismatches  <= fail_count;
  end

endmodule

// ===== sim/tb_space_vector_pwm_timing.sv =====
// ----------------------------------------------------------------------------
// Space vector PWM timing: testbench top
// Drives alpha/beta voltage transactions in random bursts across a series of
// PWM period settings, zero and full scale among them. A checker beside the
// block predicts every result; this module only makes stimulus and reports.
// ----------------------------------------------------------------------------
module tb_space_vector_pwm_timing;

  import svpwm_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT     = 200000;
  localparam int RANDOM_PER_STEP = 80;
  localparam int PERIOD_STEPS    = 8;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  svpwm_in_t   volts = '0;
  logic        result_valid;
  svpwm_out_t  result;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [15:0] cfg_data = '0;
  int          outstanding;
  int          mismatches;

  int          cycle_count = 0;
  int          items_sent = 0;
  int          burst_left = 0;

  always #1 clk = ~clk;

  space_vector_pwm_timing i_dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .volts        (volts),
    .result_valid (result_valid),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data)
  );

  svpwm_timing_checker i_checker (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .volts        (volts),
    .result_valid (result_valid),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .outstanding  (outstanding),
    .mismatches   (mismatches)
  );

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("space_vector_pwm_timing verification failed");
      $finish;
    end
  end

  // Present one transaction and hold it until the block takes it. Bursts end
  // with a random gap; the last transaction of a step always drops start.
  task automatic drive_volts(logic [15:0] alpha, logic [15:0] beta, bit last);
    int gap;
    start <= 1'b1;
    volts <= '{alpha_volts: alpha, beta_volts: beta};
    do @(posedge clk); while (busy);
    items_sent++;
    if (burst_left > 0) burst_left--;
    if (last || burst_left == 0) begin
      gap = last ? 1 : $urandom_range(1, 12);
      start <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
    end
  endtask

  // Wait until every outstanding transaction has produced its result.
  task automatic wait_drained();
    do @(posedge clk); while (outstanding != 0);
  endtask

  task automatic write_period(logic [15:0] period);
    cfg_valid <= 1'b1;
    cfg_data  <= period;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // Mostly full-range voltages, with small magnitudes and rails mixed in.
  function automatic logic [15:0] random_volts();
    int pick;
    pick = $urandom_range(0, 9);
    case (pick)
      0: begin
        case ($urandom_range(0, 4))
          0: return 16'h8000;
          1: return 16'h7fff;
          2: return 16'h0000;
          3: return 16'hffff;
          default: return 16'h0001;
        endcase
      end
      1, 2: begin
        if ($urandom_range(0, 1) == 1) return 16'($urandom_range(0, 2000));
        return -16'($urandom_range(0, 2000));
      end
      default: return 16'($urandom);
    endcase
  endfunction

  // Directed points: rails, one point inside each sector and the sector edges.
  logic [15:0] dir_alpha[21] = '{
    16'sd0, 16'sd32767, -16'sd32768, 16'sd0, 16'sd0, 16'sd32767, -16'sd32768,
    16'sd32767, -16'sd32768, -16'sd1, 16'sd1,
    16'sd13856, 16'sd0, -16'sd13856, -16'sd13856, 16'sd0, 16'sd13856,
    16'sd8192, -16'sd8192, 16'sd8192, -16'sd8192
  };
  logic [15:0] dir_beta[21] = '{
    16'sd0, 16'sd0, 16'sd0, 16'sd32767, -16'sd32768, 16'sd32767, -16'sd32768,
    -16'sd32768, 16'sd32767, -16'sd1, 16'sd1,
    16'sd8000, 16'sd16000, 16'sd8000, -16'sd8000, -16'sd16000, -16'sd8000,
    16'sd14189, 16'sd14189, -16'sd14189, -16'sd14189
  };

  // Reset, then one step per period setting, each drained before the next write.
  initial begin
    logic [15:0] periods[PERIOD_STEPS];
    periods = '{16'hffff, 16'h0000, 16'h0001, 16'd40000, 16'($urandom),
                16'($urandom_range(1, 100)), 16'h8000, 16'($urandom)};
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    for (int step = 0; step < PERIOD_STEPS; step++) begin
      write_period(periods[step]);
      if (step == 0) begin
        for (int i = 0; i < 21; i++) drive_volts(dir_alpha[i], dir_beta[i], 1'b0);
      end
      for (int i = 0; i < RANDOM_PER_STEP; i++) begin
        drive_volts(random_volts(), random_volts(), i == RANDOM_PER_STEP - 1);
        // Halfway through one step the sender holds off until the pipe is empty.
        if (step == 3 && i == RANDOM_PER_STEP / 2) begin
          start <= 1'b0;
          wait_drained();
        end
      end
      wait_drained();
    end

    repeat (30) @(posedge clk);
    $display("Ran %0d voltage transactions over %0d PWM period settings,", items_sent,
             PERIOD_STEPS);
    $display("covering all six sectors, overmodulation and a zero period.");
    if (mismatches == 0) begin
      $display("space_vector_pwm_timing verification clean");
    end else begin
      $display("space_vector_pwm_timing verification failed");
    end
    $finish;
  end

endmodule
